/* design/ilvt_pkg.sv */
// Shared types and constants of the integer literal value and type block.
`default_nettype none

package ilvt_pkg;

    // Bit widths of the C integer types.
    localparam int INT_BITS       = 32;
    localparam int LONG_BITS      = 64;
    localparam int LONG_LONG_BITS = 64;

    localparam int VALUE_W = 64;

    // Character codes used by the digit decoder.
    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
    localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CH_UPPER_F = 8'h46;  // 'F'
    localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOWER_F = 8'h66;  // 'f'

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2
    } radix_t;

    typedef enum logic [2:0] {
        SUF_NONE = 3'd0,
        SUF_U    = 3'd1,
        SUF_L    = 3'd2,
        SUF_LL   = 3'd3,
        SUF_UL   = 3'd4,
        SUF_ULL  = 3'd5
    } suffix_t;

    typedef enum logic [2:0] {
        TY_INT    = 3'd0,
        TY_UINT   = 3'd1,
        TY_LONG   = 3'd2,
        TY_ULONG  = 3'd3,
        TY_LLONG  = 3'd4,
        TY_ULLONG = 3'd5
    } type_code_t;

    // A finished literal handed from the accumulator to the result stage.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overflowed;
        logic               is_decimal;
        logic [2:0]         suffix;
    } fin_t;

endpackage

`default_nettype wire

/* design/ilvt_if.sv */
// Channel interfaces: digit characters in, literal results out.
`default_nettype none

interface ilvt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_char;
    logic [1:0] radix_kind;
    logic [2:0] suffix_kind;
    logic       last_digit;

    modport source (output valid, digit_char, radix_kind, suffix_kind, last_digit,
                    input ready);
    modport sink   (input valid, digit_char, radix_kind, suffix_kind, last_digit,
                    output ready);
endinterface

interface ilvt_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] literal_value;
    logic [2:0]  type_code;
    logic        too_large;

    modport source (output valid, literal_value, type_code, too_large, input ready);
    modport sink   (input valid, literal_value, type_code, too_large, output ready);
endinterface

`default_nettype wire

/* design/ilvt_accum.sv */
// Input register, digit decoder and the value * radix + digit accumulator.
`default_nettype none

module ilvt_accum
    import ilvt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ilvt_in_if.sink   digits,
    input  wire logic slot_free,
    output logic      fin_valid,
    output fin_t      fin
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_char_reg;
    logic [1:0] s1_radix_reg;
    logic [2:0] s1_suffix_reg;
    logic       s1_last_reg;

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic               ovf_reg;
    logic               ovf_next;

    logic               s1_adv;
    logic               in_take;
    logic [3:0]         digit;
    logic [VALUE_W+3:0] prod;
    logic               prod_ovf;
    logic [VALUE_W-1:0] new_acc;
    logic               new_ovf;

    // A non-final item leaves no result, so it never waits on the output side.
    assign s1_adv       = s1_valid_reg && (!s1_last_reg || slot_free);
    assign digits.ready = !s1_valid_reg || s1_adv;
    assign in_take      = digits.valid && digits.ready;

    always_comb
    begin
        digit = 4'd0;
        if (s1_char_reg >= CH_ZERO && s1_char_reg <= CH_NINE)
        begin
            digit = s1_char_reg[3:0];
            if (s1_radix_reg == RADIX_OCT && digit > 4'd7)
            begin
                digit = 4'd0;
            end
        end
        else if (s1_radix_reg == RADIX_HEX)
        begin
            if (s1_char_reg >= CH_UPPER_A && s1_char_reg <= CH_UPPER_F)
            begin
                digit = 4'(s1_char_reg - CH_UPPER_A + 8'd10);
            end
            else if (s1_char_reg >= CH_LOWER_A && s1_char_reg <= CH_LOWER_F)
            begin
                digit = 4'(s1_char_reg - CH_LOWER_A + 8'd10);
            end
        end
    end

    // Multiplying by a constant radix is a shift, or two shifts and an add.
    always_comb
    begin
        case (s1_radix_reg)
            RADIX_HEX: prod = {acc_reg, 4'b0000} + {{VALUE_W{1'b0}}, digit};
            RADIX_OCT: prod = {1'b0, acc_reg, 3'b000} + {{VALUE_W{1'b0}}, digit};
            default:   prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                              + {{VALUE_W{1'b0}}, digit};
        endcase
        prod_ovf = (prod[VALUE_W+3:VALUE_W] != 4'd0);
    end

    always_comb
    begin
        if (ovf_reg)
        begin
            new_acc = acc_reg;
            new_ovf = 1'b1;
        end
        else if (prod_ovf)
        begin
            new_acc = {VALUE_W{1'b1}};
            new_ovf = 1'b1;
        end
        else
        begin
            new_acc = prod[VALUE_W-1:0];
            new_ovf = 1'b0;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (s1_adv)
        begin
            acc_next = s1_last_reg ? {VALUE_W{1'b0}} : new_acc;
            ovf_next = s1_last_reg ? 1'b0 : new_ovf;
        end
        s1_valid_next = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    end

    assign fin_valid      = s1_valid_reg && s1_last_reg;
    assign fin.value      = new_acc;
    assign fin.overflowed = new_ovf;
    assign fin.is_decimal = (s1_radix_reg != RADIX_HEX) && (s1_radix_reg != RADIX_OCT);
    assign fin.suffix     = s1_suffix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg   <= digits.digit_char;
            s1_radix_reg  <= digits.radix_kind;
            s1_suffix_reg <= digits.suffix_kind;
            s1_last_reg   <= digits.last_digit;
        end
    end

endmodule

`default_nettype wire

/* design/ilvt_result.sv */
// Type selection over the candidate list and the result register.
`default_nettype none

module ilvt_result
    import ilvt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   fin_valid,
    input  wire fin_t   fin,
    output logic        slot_free,
    ilvt_out_if.source  result
);

    // True when the value needs no more than w magnitude bits.
    function automatic logic fits(input logic [VALUE_W-1:0] v, input int w);
        logic r;
        if (w >= VALUE_W)
        begin
            r = 1'b1;
        end
        else
        begin
            r = ((v >> w) == {VALUE_W{1'b0}});
        end
        return r;
    endfunction

    logic       f_int;
    logic       f_uint;
    logic       f_long;
    logic       f_ulong;
    logic       f_llong;
    logic       f_ullong;
    logic       found;
    type_code_t code;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_value_reg;
    logic [2:0]  out_code_reg;
    logic        out_large_reg;
    logic        load;

    assign f_int    = fits(fin.value, INT_BITS - 1);
    assign f_uint   = fits(fin.value, INT_BITS);
    assign f_long   = fits(fin.value, LONG_BITS - 1);
    assign f_ulong  = fits(fin.value, LONG_BITS);
    assign f_llong  = fits(fin.value, LONG_LONG_BITS - 1);
    assign f_ullong = fits(fin.value, LONG_LONG_BITS);

    // First candidate that holds the value wins; decimal literals without
    // a U suffix never fall back to an unsigned type.
    always_comb
    begin
        found = 1'b1;
        code  = TY_INT;
        unique case (fin.suffix)
            SUF_U:
            begin
                if (f_uint)        code = TY_UINT;
                else if (f_ulong)  code = TY_ULONG;
                else if (f_ullong) code = TY_ULLONG;
                else               found = 1'b0;
            end
            SUF_L:
            begin
                if (f_long)                         code = TY_LONG;
                else if (!fin.is_decimal && f_ulong) code = TY_ULONG;
                else if (f_llong)                   code = TY_LLONG;
                else if (!fin.is_decimal && f_ullong) code = TY_ULLONG;
                else                                found = 1'b0;
            end
            SUF_LL:
            begin
                if (f_llong)                          code = TY_LLONG;
                else if (!fin.is_decimal && f_ullong) code = TY_ULLONG;
                else                                  found = 1'b0;
            end
            SUF_UL:
            begin
                if (f_ulong)       code = TY_ULONG;
                else if (f_ullong) code = TY_ULLONG;
                else               found = 1'b0;
            end
            SUF_ULL:
            begin
                if (f_ullong) code = TY_ULLONG;
                else          found = 1'b0;
            end
            default:
            begin
                if (f_int)                            code = TY_INT;
                else if (!fin.is_decimal && f_uint)   code = TY_UINT;
                else if (f_long)                      code = TY_LONG;
                else if (!fin.is_decimal && f_ulong)  code = TY_ULONG;
                else if (f_llong)                     code = TY_LLONG;
                else if (!fin.is_decimal && f_ullong) code = TY_ULLONG;
                else                                  found = 1'b0;
            end
        endcase
        if (fin.overflowed)
        begin
            found = 1'b0;
        end
    end

    assign slot_free      = !out_valid_reg || result.ready;
    assign load           = fin_valid && slot_free;
    assign out_valid_next = load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg <= found ? fin.value : 64'd0;
            out_code_reg  <= found ? code : TY_INT;
            out_large_reg <= !found;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.literal_value = out_value_reg;
    assign result.type_code     = out_code_reg;
    assign result.too_large     = out_large_reg;

endmodule

`default_nettype wire

/* design/integer_literal_value_and_type.sv */
// Top level: parses C integer literal digits into a value and its deduced type.
//
// The digits channel takes one character of a literal per item, with the
// radix prefix already removed; radix_kind and suffix_kind ride on each item,
// and only those of the final item (last_digit high) select the type list.
// The result channel gives one item per literal: the value, the first
// candidate type that holds it, or too_large with value and type zero.
// An item is registered at the input, accumulated as value * radix + digit,
// and a final item is classified into the result register. A last character
// goes through the input register into the result register, where its
// result turns valid. One character is taken every cycle while results are
// taken. Non-final characters keep flowing while a result waits; a final
// character waits in the input register until the result register is free,
// and input ready is low while it waits. Reset clears the accumulator, the
// overflow flag and both valid flags; items in flight at reset are dropped.
`default_nettype none

module integer_literal_value_and_type
    import ilvt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ilvt_in_if.sink    digits,
    ilvt_out_if.source result
);

    logic fin_valid;
    fin_t fin;
    logic slot_free;

    ilvt_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .digits    (digits),
        .slot_free (slot_free),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    ilvt_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .slot_free (slot_free),
        .result    (result)
    );

`ifndef NO_ASSERTIONS
    a_large_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.too_large |->
            result.literal_value == 64'd0 && result.type_code == TY_INT)
        else $error("too_large result carries a nonzero value or type");

    a_fin_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && slot_free |=> result.valid)
        else $error("finished literal did not reach the result register");

    a_ovf_large: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && slot_free && fin.overflowed |=> result.too_large)
        else $error("overflowed literal not flagged too_large");
`endif

endmodule

`default_nettype wire

/* tb/ilvt_scoreboard_pkg.sv */
// Scoreboard for the integer literal block: digit accumulation, type choice and result checks.
package ilvt_scoreboard_pkg;

    import ilvt_pkg::*;

    typedef struct {
        logic [63:0] value;
        type_code_t  code;
        logic        too_large;
    } literal_result_t;

    typedef type_code_t type_list_t[$];

    class literal_scoreboard;

        bit [63:0]       acc;
        bit              acc_overflow;
        literal_result_t pending_results[$];
        int              error_count;
        int              literals_checked;
        int              too_large_count;
        bit [5:0]        types_seen;

        function new();
            acc              = '0;
            acc_overflow     = 1'b0;
            error_count      = 0;
            literals_checked = 0;
            too_large_count  = 0;
            types_seen       = '0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Characters that are not digits of the radix count as zero.
        function bit [63:0] digit_of(bit [7:0] ch, int radix);
            if (ch >= CH_ZERO && ch <= CH_NINE)
                return (ch - CH_ZERO < radix) ? 64'(ch - CH_ZERO) : 64'd0;
            if (radix == 16 && ch >= CH_UPPER_A && ch <= CH_UPPER_F)
                return 64'(ch - CH_UPPER_A + 10);
            if (radix == 16 && ch >= CH_LOWER_A && ch <= CH_LOWER_F)
                return 64'(ch - CH_LOWER_A + 10);
            return 64'd0;
        endfunction

        function bit [63:0] type_limit(type_code_t code);
            int        bits;
            bit [63:0] umax;
            case (code)
                TY_INT, TY_UINT:   bits = INT_BITS;
                TY_LONG, TY_ULONG: bits = LONG_BITS;
                default:           bits = LONG_LONG_BITS;
            endcase
            umax = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
            if (code == TY_INT || code == TY_LONG || code == TY_LLONG)
                return umax >> 1;
            return umax;
        endfunction

        function type_list_t candidates(bit is_decimal, suffix_t suffix);
            type_list_t list;
            if (is_decimal) begin
                case (suffix)
                    SUF_U:   list = '{TY_UINT, TY_ULONG, TY_ULLONG};
                    SUF_L:   list = '{TY_LONG, TY_LLONG};
                    SUF_LL:  list = '{TY_LLONG};
                    SUF_UL:  list = '{TY_ULONG, TY_ULLONG};
                    SUF_ULL: list = '{TY_ULLONG};
                    default: list = '{TY_INT, TY_LONG, TY_LLONG};
                endcase
            end
            else begin
                case (suffix)
                    SUF_U:   list = '{TY_UINT, TY_ULONG, TY_ULLONG};
                    SUF_L:   list = '{TY_LONG, TY_ULONG, TY_LLONG, TY_ULLONG};
                    SUF_LL:  list = '{TY_LLONG, TY_ULLONG};
                    SUF_UL:  list = '{TY_ULONG, TY_ULLONG};
                    SUF_ULL: list = '{TY_ULLONG};
                    default: list = '{TY_INT, TY_UINT, TY_LONG, TY_ULONG, TY_LLONG, TY_ULLONG};
                endcase
            end
            return list;
        endfunction

        function void note_digit(bit [7:0] ch, bit [1:0] radix_kind, bit [2:0] suffix_kind,
                                 bit last);
            int              radix;
            bit [63:0]       d;
            suffix_t         suffix;
            type_list_t      list;
            literal_result_t res;
            radix = (radix_kind == RADIX_HEX) ? 16 : (radix_kind == RADIX_OCT) ? 8 : 10;
            d     = digit_of(ch, radix);
            // Saturate once value * radix + digit no longer fits in 64 bits.
            if (!acc_overflow) begin
                if (acc > ('1 - d) / 64'(radix)) begin
                    acc_overflow = 1'b1;
                    acc          = '1;
                end
                else begin
                    acc = acc * 64'(radix) + d;
                end
            end
            if (!last)
                return;
            suffix        = (suffix_kind > SUF_ULL) ? SUF_NONE : suffix_t'(suffix_kind);
            list          = candidates(radix == 10, suffix);
            res.value     = '0;
            res.code      = TY_INT;
            res.too_large = 1'b1;
            if (!acc_overflow) begin
                foreach (list[i]) begin
                    if (res.too_large && acc <= type_limit(list[i])) begin
                        res.value     = acc;
                        res.code      = list[i];
                        res.too_large = 1'b0;
                    end
                end
            end
            pending_results.push_back(res);
            acc          = '0;
            acc_overflow = 1'b0;
        endfunction

        function void check_result(logic [63:0] value, logic [2:0] code, logic too_large);
            literal_result_t exp_res;
            if (pending_results.size() == 0) begin
                $error("Result with no literal pending: value %h type %0d too_large %b",
                       value, code, too_large);
                error_count++;
                return;
            end
            exp_res = pending_results.pop_front();
            literals_checked++;
            if (exp_res.too_large)
                too_large_count++;
            else
                types_seen[exp_res.code] = 1'b1;
            if (value !== exp_res.value) begin
                $error("literal_value: expected %h, got %h", exp_res.value, value);
                error_count++;
            end
            if (code !== exp_res.code) begin
                $error("type_code: expected %0d, got %0d", exp_res.code, code);
                error_count++;
            end
            if (too_large !== exp_res.too_large) begin
                $error("too_large: expected %b, got %b", exp_res.too_large, too_large);
                error_count++;
            end
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench of the integer literal value and type block.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ilvt_pkg::*;
    import ilvt_scoreboard_pkg::*;

    typedef bit [7:0] char_q_t[$];

    localparam bit [1:0] RADIX_UNUSED  = 2'd3;
    localparam bit [2:0] SUF_UNUSED_6  = 3'd6;
    localparam bit [2:0] SUF_UNUSED_7  = 3'd7;
    localparam int       RANDOM_ITEMS  = 400;
    localparam int       CYCLE_LIMIT   = 200000;
    localparam int       DRAIN_CYCLES  = 10;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   chars_sent;
    int   cycle_count;

    literal_scoreboard sb;

    ilvt_in_if  digits_if();
    ilvt_out_if result_if();

    integer_literal_value_and_type dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .digits (digits_if),
        .result (result_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit [7:0] digit_char_of(int d, bit upper);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
    endfunction

    function automatic char_q_t to_digits(bit [63:0] v, int radix, bit upper);
        char_q_t q;
        do
        begin
            q.push_front(digit_char_of(int'(v % 64'(radix)), upper));
            v = v / 64'(radix);
        end
        while (v != 0);
        return q;
    endfunction

    task automatic send_char(input bit [7:0] ch, input bit [1:0] radix_kind,
                             input bit [2:0] suffix_kind, input bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            digits_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        digits_if.digit_char  <= ch;
        digits_if.radix_kind  <= radix_kind;
        digits_if.suffix_kind <= suffix_kind;
        digits_if.last_digit  <= last;
        digits_if.valid       <= 1'b1;
        do @(posedge clk); while (!digits_if.ready);
        sb.note_digit(ch, radix_kind, suffix_kind, last);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit [1:0] radix_kind,
                             input bit [2:0] suffix_kind);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], radix_kind, suffix_kind, i == s.len() - 1);
    endtask

    // Only the last character selects the type list, so earlier ones carry
    // random suffixes and now and then another radix.
    task automatic send_literal(input char_q_t chars, input bit [1:0] radix_kind,
                                input bit [2:0] suffix_kind);
        bit [1:0] rk;
        for (int i = 0; i < chars.size() - 1; i++)
        begin
            rk = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : radix_kind;
            send_char(chars[i], rk, 3'($urandom_range(0, 7)), 1'b0);
        end
        send_char(chars[chars.size() - 1], radix_kind, suffix_kind, 1'b1);
    endtask

    // Result side: a random stall before each result, none while no_idle is set.
    initial
    begin
        int stall;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!(result_if.valid && result_if.ready));
            sb.check_result(result_if.literal_value, result_if.type_code,
                            result_if.too_large);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        bit [63:0] boundaries[8];
        char_q_t   chars;
        bit [1:0]  rk;
        bit [2:0]  sk;
        bit [63:0] v;
        int        mode;
        int        radix;
        int        len;
        bit        upper;

        boundaries = '{64'd0, 64'h7FFF, 64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF,
                       64'h1_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        sb         = new();
        no_idle    = 1'b0;
        chars_sent = 0;

        rst_n                 = 1'b0;
        digits_if.valid       = 1'b0;
        digits_if.digit_char  = '0;
        digits_if.radix_kind  = '0;
        digits_if.suffix_kind = '0;
        digits_if.last_digit  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed literals: field extremes, invalid digits, unused codes,
        // a radix change on the last character and the int/unsigned edge.
        send_text("0", RADIX_DEC, SUF_NONE);
        send_text("fF", RADIX_HEX, SUF_L);
        send_text("19", RADIX_OCT, SUF_ULL);
        send_text("7", RADIX_UNUSED, SUF_UNUSED_6);
        send_text("A", RADIX_DEC, SUF_UL);
        send_text("1", RADIX_DEC, SUF_U);
        send_text("5", RADIX_HEX, SUF_LL);
        send_char(8'hFF, RADIX_HEX, SUF_UNUSED_7, 1'b0);
        send_char(8'h00, RADIX_HEX, SUF_UNUSED_7, 1'b1);
        send_char("1", RADIX_HEX, SUF_NONE, 1'b0);
        send_char("2", RADIX_OCT, SUF_U, 1'b1);
        send_text("80000000", RADIX_HEX, SUF_NONE);

        while (chars_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                no_idle = ~no_idle;
            rk    = ($urandom_range(0, 15) == 0) ? RADIX_UNUSED : 2'($urandom_range(0, 2));
            sk    = 3'($urandom_range(0, 7));
            radix = (rk == RADIX_HEX) ? 16 : (rk == RADIX_OCT) ? 8 : 10;
            upper = 1'($urandom_range(0, 1));
            mode  = $urandom_range(0, 9);
            chars.delete();
            if (mode <= 2)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                    chars.push_back(digit_char_of($urandom_range(0, radix - 1),
                                                  1'($urandom_range(0, 1))));
            end
            else if (mode <= 5)
            begin
                // Values next to the limits of the integer types.
                v     = boundaries[$urandom_range(0, 7)] - 64'd2 + 64'($urandom_range(0, 4));
                chars = to_digits(v, radix, upper);
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
                    chars.push_front(CH_ZERO);
            end
            else if (mode <= 7)
            begin
                // One digit more than the largest value that cannot overflow.
                v     = ('1 / 64'(radix)) - 64'd1 + 64'($urandom_range(0, 2));
                chars = to_digits(v, radix, upper);
                chars.push_back(digit_char_of($urandom_range(0, radix - 1), upper));
            end
            else if (mode == 8)
            begin
                len = $urandom_range(1, 24);
                repeat (len)
                    chars.push_back(digit_char_of($urandom_range(0, radix - 1),
                                                  1'($urandom_range(0, 1))));
            end
            else
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                    chars.push_back(8'($urandom_range(0, 255)));
            end
            send_literal(chars, rk, sk);
        end

        @(negedge clk);
        digits_if.valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d characters; checked %0d literals, %0d of them too large.",
                 chars_sent, sb.literals_checked, sb.too_large_count);
        $display("Result types seen (bit per type code, unsigned long long on the left): %b",
                 sb.types_seen);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
design/ilvt_pkg.sv
design/ilvt_if.sv
design/ilvt_accum.sv
design/ilvt_result.sv
design/integer_literal_value_and_type.sv
tb/ilvt_scoreboard_pkg.sv
tb/tb_top.sv
